[rtl/ncmc_pkg.sv]
// Shared types and constants of the nearest class mean classifier.
// Used by every module of the block; depends on nothing.
package ncmc_pkg;

  localparam int MaxClasses = 64;
  localparam int MaxDims    = 256;

  localparam int ElemW   = 32;
  localparam int CountW  = 16;
  localparam int DistW   = 64;
  localparam int ActW    = 3;
  localparam int ClsW    = 6;
  localparam int CfgClsW = 7;
  localparam int CfgDimW = 9;

  localparam logic [DistW-1:0]  DistCap  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [CountW-1:0] CountMax = 16'hFFFF;

  typedef enum logic [ActW-1:0] {
    ACT_ACCUM     = 3'd0,
    ACT_OVERWRITE = 3'd1,
    ACT_CLASSIFY  = 3'd2,
    ACT_READ_MEAN = 3'd3,
    ACT_CLEAR     = 3'd4
  } action_e;

  typedef enum logic {
    CFG_ACTIVE_CLASSES = 1'b0,
    CFG_ACTIVE_DIMS    = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    RES_MEAN   = 1'b0,
    RES_ANSWER = 1'b1
  } result_kind_e;

  typedef enum logic [1:0] {
    OP_STORE,
    OP_MEAN,
    OP_CLASSIFY
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EVAL,
    ST_DIV,
    ST_SQ,
    ST_ACC,
    ST_EMIT
  } state_e;

endpackage

[rtl/ncmc_div.sv]
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
// Depends on ncmc_pkg for widths.
module ncmc_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [ncmc_pkg::ElemW-1:0]   dividend_i,
  input  logic        [ncmc_pkg::CountW-1:0]  divisor_i,
  output logic                                done_o,
  output logic signed [ncmc_pkg::ElemW-1:0]   quot_o
);

  localparam int EW = ncmc_pkg::ElemW;
  localparam int NW = ncmc_pkg::CountW;
  localparam int SW = $clog2(EW);

  logic          busy_q, done_q;
  logic [SW-1:0] step_q;
  logic [EW-1:0] quo_q;
  logic [NW-1:0] rem_q, div_q;
  logic          neg_q;

  logic [NW:0]   rem_sh, rem_sub;
  logic          ge;

  always_comb begin
    rem_sh  = {rem_q, quo_q[EW-1]};
    ge      = rem_sh >= {1'b0, div_q};
    rem_sub = rem_sh - {1'b0, div_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == SW'(EW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i[EW-1] ? -dividend_i : dividend_i;
      neg_q <= dividend_i[EW-1];
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[EW-2:0], ge};
      rem_q <= ge ? rem_sub[NW-1:0] : rem_sh[NW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -quo_q : quo_q;

endmodule

[rtl/ncmc_dist.sv]
// Distance step: difference, registered square, saturating accumulate.
// Depends on ncmc_pkg for widths and the distance cap.
module ncmc_dist (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [ncmc_pkg::ElemW-1:0]  mean_i,
  input  logic signed [ncmc_pkg::ElemW-1:0]  elem_i,
  input  logic        [ncmc_pkg::DistW-1:0]  acc_i,
  output logic        [ncmc_pkg::DistW-1:0]  sum_o
);

  localparam int EW = ncmc_pkg::ElemW;
  localparam int DW = ncmc_pkg::DistW;

  logic [EW:0]   diff, mag;
  logic [DW-1:0] sq_q;
  logic          ovf_q;

  always_comb begin
    diff = {mean_i[EW-1], mean_i} - {elem_i[EW-1], elem_i};
    mag  = diff[EW] ? -diff : diff;
  end

  // Magnitude at or above 2^32 squares past the cap.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q  <= DW'(mag[EW-1:0]) * DW'(mag[EW-1:0]);
      ovf_q <= mag[EW];
    end
  end

  always_comb begin
    if (ovf_q || sq_q >= ncmc_pkg::DistCap || acc_i >= ncmc_pkg::DistCap - sq_q) begin
      sum_o = ncmc_pkg::DistCap;
    end else begin
      sum_o = acc_i + sq_q;
    end
  end

endmodule

[rtl/nearest_class_mean_classifier_core.sv]
// Nearest class mean classifier: prototype store, mean readout and classification.
// Depends on ncmc_pkg, ncmc_div and ncmc_dist.
//
//  channel  dir  handshake                  payload
//  s_axis   in   s_axis_tvalid/tready       tuser: action; tdata: class_index, element_value
//  m_axis   out  m_axis_tvalid/tready       tuser: result_kind, class_empty;
//                                           tdata: mean_value, best_class
//  cfg      in   cfg_we_i (no wait)         cfg_idx_i, cfg_wdata_i
//
// A classify element visits every active class in turn, skipping the divider for empty
// ones, because every class mean goes through the one shared divider and distance unit.
// Reset empties all classes and zeroes the position; sums stay undefined.
// A waiting result holds in the output register; a new item is taken meanwhile,
// and only a second result stalls in the emit state until the first leaves.
module nearest_class_mean_classifier_core #(
  parameter int MAX_CLASSES = ncmc_pkg::MaxClasses,
  parameter int MAX_DIMS    = ncmc_pkg::MaxDims
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [5:0] class_index, [37:6] element_value, [39:38] zero
  input  logic [2:0]  s_axis_tuser,   // [2:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] mean_value, [37:32] best_class, [39:38] zero
  output logic [1:0]  m_axis_tuser,   // [0] result_kind, [1] class_empty
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [8:0]  cfg_wdata_i
);

  localparam int EW  = ncmc_pkg::ElemW;
  localparam int NW  = ncmc_pkg::CountW;
  localparam int DW  = ncmc_pkg::DistW;
  localparam int CW  = $clog2(MAX_CLASSES);
  localparam int PW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int AW  = CW + PW;
  localparam int NCW = (CW + 1 > ncmc_pkg::CfgClsW) ? CW + 1 : ncmc_pkg::CfgClsW;
  localparam int NDW = (PW + 1 > ncmc_pkg::CfgDimW) ? PW + 1 : ncmc_pkg::CfgDimW;

  // Input unpack.
  logic [ncmc_pkg::ClsW-1:0] in_cls;
  logic signed [EW-1:0]      in_elem;
  logic [ncmc_pkg::ActW-1:0] in_act;
  assign in_cls  = s_axis_tdata[5:0];
  assign in_elem = s_axis_tdata[37:6];
  assign in_act  = s_axis_tuser;

  // Configuration.
  logic [ncmc_pkg::CfgClsW-1:0] cfg_cls_q;
  logic [ncmc_pkg::CfgDimW-1:0] cfg_dim_q;
  logic [NCW-1:0] ncls;
  logic [NDW-1:0] ndims;
  logic [CW-1:0]  ncls_m1;
  logic [PW-1:0]  dims_m1;

  always_comb begin
    if (cfg_cls_q == '0) ncls = NCW'(1);
    else if (NCW'(cfg_cls_q) > NCW'(MAX_CLASSES)) ncls = NCW'(MAX_CLASSES);
    else ncls = NCW'(cfg_cls_q);
    if (cfg_dim_q == '0) ndims = NDW'(1);
    else if (NDW'(cfg_dim_q) > NDW'(MAX_DIMS)) ndims = NDW'(MAX_DIMS);
    else ndims = NDW'(cfg_dim_q);
    ncls_m1 = CW'(ncls - NCW'(1));
    dims_m1 = PW'(ndims - NDW'(1));
  end

  // Sequencer state and item context.
  ncmc_pkg::state_e state_q, state_d;
  ncmc_pkg::op_e    op_q;
  logic             ovw_q, active_q, last_q, empty_q;
  logic [CW-1:0]    cls_q;
  logic [PW-1:0]    pos_q, pos_cur_q;
  logic signed [EW-1:0] elem_q, mean_q;
  logic [DW-1:0]    best_q;
  logic [CW-1:0]    best_idx_q;
  logic [MAX_CLASSES-1:0] cnt_vld_q, acc_vld_q;

  // Memories and their registered read data.
  logic [EW-1:0] sum_mem [2**AW];
  logic [NW-1:0] cnt_mem [MAX_CLASSES];
  logic [DW-1:0] acc_mem [MAX_CLASSES];
  logic [EW-1:0] sum_rd_q;
  logic [NW-1:0] cnt_rd_q;
  logic [DW-1:0] acc_rd_q;

  // Output register.
  logic                 out_vld_q;
  logic                 out_kind_q, out_empty_q;
  logic [EW-1:0]        out_mean_q;
  logic [ncmc_pkg::ClsW-1:0] out_best_q;

  // Control strobes.
  logic accept, in_active, in_last, cur_vld;
  logic store_we, cnt_we, div_start, div_done, dist_en, acc_we, advance, out_load;
  logic signed [EW-1:0] div_quot;
  logic [EW-1:0] sum_wdata;
  logic [NW-1:0] cnt_wdata;
  logic [DW-1:0] acc_old, dist_sum;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign in_active = NCW'(in_cls) < ncls;
  assign in_last   = pos_q == dims_m1;
  assign cur_vld   = active_q && cnt_vld_q[cls_q];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ncmc_pkg::ST_IDLE: begin
        if (accept && (in_act == ncmc_pkg::ACT_ACCUM || in_act == ncmc_pkg::ACT_OVERWRITE
                       || in_act == ncmc_pkg::ACT_CLASSIFY
                       || in_act == ncmc_pkg::ACT_READ_MEAN)) begin
          state_d = ncmc_pkg::ST_FETCH;
        end
      end
      ncmc_pkg::ST_FETCH: state_d = ncmc_pkg::ST_EVAL;
      ncmc_pkg::ST_EVAL: begin
        unique case (op_q)
          ncmc_pkg::OP_STORE: state_d = ncmc_pkg::ST_IDLE;
          ncmc_pkg::OP_MEAN:  state_d = cur_vld ? ncmc_pkg::ST_DIV : ncmc_pkg::ST_EMIT;
          default: begin
            if (cur_vld) state_d = ncmc_pkg::ST_DIV;
            else if (cls_q != ncls_m1) state_d = ncmc_pkg::ST_FETCH;
            else state_d = last_q ? ncmc_pkg::ST_EMIT : ncmc_pkg::ST_IDLE;
          end
        endcase
      end
      ncmc_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = (op_q == ncmc_pkg::OP_MEAN) ? ncmc_pkg::ST_EMIT : ncmc_pkg::ST_SQ;
        end
      end
      ncmc_pkg::ST_SQ: state_d = ncmc_pkg::ST_ACC;
      ncmc_pkg::ST_ACC: begin
        if (cls_q != ncls_m1) state_d = ncmc_pkg::ST_FETCH;
        else state_d = last_q ? ncmc_pkg::ST_EMIT : ncmc_pkg::ST_IDLE;
      end
      ncmc_pkg::ST_EMIT: begin
        if (!out_vld_q || m_axis_tready) state_d = ncmc_pkg::ST_IDLE;
      end
      default: state_d = ncmc_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    s_axis_tready = state_q == ncmc_pkg::ST_IDLE;
    store_we  = state_q == ncmc_pkg::ST_EVAL && op_q == ncmc_pkg::OP_STORE && active_q;
    cnt_we    = store_we && last_q;
    div_start = state_q == ncmc_pkg::ST_EVAL && op_q != ncmc_pkg::OP_STORE && cur_vld;
    dist_en   = state_q == ncmc_pkg::ST_SQ;
    acc_we    = state_q == ncmc_pkg::ST_ACC;
    advance   = acc_we || (state_q == ncmc_pkg::ST_EVAL
                           && op_q == ncmc_pkg::OP_CLASSIFY && !cur_vld);
    out_load  = state_q == ncmc_pkg::ST_EMIT && (!out_vld_q || m_axis_tready);
  end

  // Fresh class or overwrite: take the element, count one; otherwise add (wrapping), count up (saturating).
  always_comb begin
    sum_wdata = (ovw_q || !cnt_vld_q[cls_q]) ? elem_q : sum_rd_q + elem_q;
    if (ovw_q || !cnt_vld_q[cls_q]) cnt_wdata = NW'(1);
    else if (cnt_rd_q == ncmc_pkg::CountMax) cnt_wdata = cnt_rd_q;
    else cnt_wdata = cnt_rd_q + NW'(1);
    acc_old = acc_vld_q[cls_q] ? acc_rd_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ncmc_pkg::ST_IDLE;
      cfg_cls_q <= ncmc_pkg::CfgClsW'(64);
      cfg_dim_q <= ncmc_pkg::CfgDimW'(256);
      pos_q     <= '0;
      cnt_vld_q <= '0;
      acc_vld_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        // A write restarts the vector, unless an item is accepted in the same cycle.
        pos_q <= '0;
        unique case (ncmc_pkg::cfg_reg_e'(cfg_idx_i))
          ncmc_pkg::CFG_ACTIVE_CLASSES: cfg_cls_q <= cfg_wdata_i[ncmc_pkg::CfgClsW-1:0];
          default:                      cfg_dim_q <= cfg_wdata_i;
        endcase
      end
      if (accept) begin
        priority if (in_act == ncmc_pkg::ACT_CLEAR) begin
          pos_q     <= '0;
          cnt_vld_q <= '0;
          acc_vld_q <= '0;
        end else if (in_act == ncmc_pkg::ACT_ACCUM || in_act == ncmc_pkg::ACT_OVERWRITE
                     || in_act == ncmc_pkg::ACT_READ_MEAN) begin
          pos_q <= in_last ? '0 : pos_q + 1'b1;
        end else if (in_act == ncmc_pkg::ACT_CLASSIFY) begin
          pos_q <= in_last ? '0 : pos_q + 1'b1;
          if (pos_q == '0) acc_vld_q <= '0;
        end else begin
          pos_q <= pos_q;
        end
      end
      if (cnt_we) cnt_vld_q[cls_q] <= 1'b1;
      if (acc_we) acc_vld_q[cls_q] <= 1'b1;
      if (out_load) out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
    end
  end

  // Item context and payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      elem_q    <= in_elem;
      pos_cur_q <= pos_q;
      last_q    <= in_last;
      ovw_q     <= in_act == ncmc_pkg::ACT_OVERWRITE;
      best_q    <= ncmc_pkg::DistCap;
      best_idx_q <= '0;
      if (in_act == ncmc_pkg::ACT_CLASSIFY) begin
        op_q     <= ncmc_pkg::OP_CLASSIFY;
        cls_q    <= '0;
        active_q <= 1'b1;
      end else begin
        op_q     <= (in_act == ncmc_pkg::ACT_READ_MEAN) ? ncmc_pkg::OP_MEAN
                                                        : ncmc_pkg::OP_STORE;
        cls_q    <= CW'(in_cls);
        active_q <= in_active;
      end
    end else if (advance) begin
      cls_q <= cls_q + 1'b1;
    end
    if (state_q == ncmc_pkg::ST_EVAL) empty_q <= !cur_vld;
    if (state_q == ncmc_pkg::ST_DIV && div_done) mean_q <= div_quot;
    // Strictly smaller wins, so ties keep the lowest class.
    if (acc_we && last_q && dist_sum < best_q) begin
      best_q     <= dist_sum;
      best_idx_q <= cls_q;
    end
    if (out_load) begin
      out_kind_q  <= (op_q == ncmc_pkg::OP_CLASSIFY) ? ncmc_pkg::RES_ANSWER
                                                     : ncmc_pkg::RES_MEAN;
      out_empty_q <= op_q == ncmc_pkg::OP_MEAN && empty_q;
      out_mean_q  <= (op_q == ncmc_pkg::OP_MEAN && !empty_q) ? mean_q : '0;
      out_best_q  <= (op_q == ncmc_pkg::OP_CLASSIFY) ? ncmc_pkg::ClsW'(best_idx_q) : '0;
    end
  end

  // Memories: one write and one registered read each per cycle.
  always_ff @(posedge clk_i) begin
    if (store_we) sum_mem[{cls_q, pos_cur_q}] <= sum_wdata;
    sum_rd_q <= sum_mem[{cls_q, pos_cur_q}];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cls_q] <= cnt_wdata;
    cnt_rd_q <= cnt_mem[cls_q];
  end

  always_ff @(posedge clk_i) begin
    if (acc_we) acc_mem[cls_q] <= dist_sum;
    acc_rd_q <= acc_mem[cls_q];
  end

  ncmc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_rd_q),
    .divisor_i  (cnt_rd_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  ncmc_dist u_dist (
    .clk_i  (clk_i),
    .en_i   (dist_en),
    .mean_i (div_quot),
    .elem_i (elem_q),
    .acc_i  (acc_old),
    .sum_o  (dist_sum)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_best_q, out_mean_q};
  assign m_axis_tuser  = {out_empty_q, out_kind_q};

endmodule

[rtl/ncmc_checker.sv]
// Port-level checks of the classifier core, attached by bind.
// Depends on nearest_class_mean_classifier_core and ncmc_pkg.
module ncmc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A mean read always goes busy after its transaction.
  a_mean_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == ncmc_pkg::ACT_READ_MEAN
    |=> !s_axis_tready)
    else $error("ready after a mean read transaction");

  // An answer carries no mean and no empty flag.
  a_answer_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[31:0] == '0 && !m_axis_tuser[1])
    else $error("answer carries mean fields");

  // An empty class reads as zero, and mean results carry no class.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0]
    |-> m_axis_tdata[37:32] == '0 && (!m_axis_tuser[1] || m_axis_tdata[31:0] == '0))
    else $error("mean result fields inconsistent");

endmodule

bind nearest_class_mean_classifier_core ncmc_checker u_ncmc_checker (.*);
